// ----- hw/rtl/dtq_pkg.sv -----
// Shared widths, codes and slot record type for the deadline timer queue.
package dtq_pkg;

  // Field widths
  localparam int ID_W     = 8;
  localparam int TIME_W   = 48;
  localparam int PERIOD_W = 32;
  localparam int ORDER_W  = 16;

  // Default number of timer slots
  localparam int DEPTH_DEF = 16;

  // Fired timers reported per tick, and counters that cover it
  localparam int MAX_FIRE   = 16;
  localparam int FIRE_IDX_W = $clog2(MAX_FIRE);
  localparam int FIRE_CNT_W = FIRE_IDX_W + 1;

  localparam logic [ORDER_W-1:0] SEQ_TOP  = '1;
  localparam logic [TIME_W-1:0]  TIME_MAX = '1;

  // Operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  // One timer slot as kept in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [ID_W-1:0]     id;
    logic                rearm;
    logic [PERIOD_W-1:0] period;
    logic [ORDER_W-1:0]  order;
  } entry_t;

  // Control from the sequencer to the minimum search
  typedef struct packed {
    logic clear;
    logic feed;
    logic cand;
    logic order_only;
  } scan_ctl_t;

endpackage

// ----- hw/rtl/dtq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data from the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/dtq_scan.sv -----
// Running minimum over a stream of slot records, keyed by deadline then order.
module dtq_scan
  import dtq_pkg::*;
#(
  parameter int IDX_W = $clog2(DEPTH_DEF)
) (
  input  logic             clk,
  input  scan_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  entry_t           word,
  output logic             found,
  output logic [IDX_W-1:0] best_idx,
  output entry_t           best
);

  logic [TIME_W+ORDER_W-1:0] key_new;
  logic [TIME_W+ORDER_W-1:0] key_best;
  logic                      better;

  // Build keys; renumbering compares by order alone
  always_comb begin
    if (ctl.order_only) begin
      key_new  = {{TIME_W{1'b0}}, word.order};
      key_best = {{TIME_W{1'b0}}, best.order};
    end else begin
      key_new  = {word.deadline, word.order};
      key_best = {best.deadline, best.order};
    end
    better = ctl.cand && (!found || (key_new < key_best));
  end

  // Hold the best candidate seen since the last clear
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.feed && better) begin
      found    <= 1'b1;
      best_idx <= idx;
      best     <= word;
    end
  end

endmodule

// ----- hw/rtl/deadline_timer_queue_core.sv -----
// Deadline timer queue: slot memory, sequencer and result buffer.
//
// Timer queue with DEPTH slots held in a synchronous slot memory. Every
// operation walks the slot memory one entry per cycle. A tick picks F expired
// timers in deadline order, walking the slots for each pick, re-arms each
// repeating one, makes one more walk for the next deadline, and then presents
// the F results one by one. When the 16-bit insertion sequence runs out, the
// next insertion first renumbers the live slots. busy is high from the accepted
// transaction until its last result is out; each result shows for exactly one
// cycle with strobe and must be taken then, and all results of one transaction
// carry the same next-deadline summary as it stands after the whole transaction.
module deadline_timer_queue_core
  import dtq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic [ID_W-1:0]     timer_id,
  input  logic [TIME_W-1:0]   deadline,
  input  logic                repeat_req,
  input  logic [PERIOD_W-1:0] period,
  input  logic [TIME_W-1:0]   now,
  output logic                strobe,
  output logic [1:0]          kind,
  output logic [ID_W-1:0]     fired_id,
  output logic [TIME_W-1:0]   fired_time,
  output logic [1:0]          status,
  output logic                next_valid,
  output logic [TIME_W-1:0]   next_deadline,
  output logic                last
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W:0] SCAN_END = (IDX_W+1)'(DEPTH);

  typedef struct packed {
    logic [IDX_W-1:0]    slot;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   deadline;
    logic                rearm;
    logic [PERIOD_W-1:0] period;
  } fire_t;

  localparam int FIRE_W  = $bits(fire_t);
  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_ORDER, S_RENUM_SCAN, S_RENUM_WRITE, S_PLACE,
    S_DEL_SCAN, S_DEL_DONE, S_DUE_SCAN, S_DUE_TAKE, S_REARM_READ,
    S_REARM_LOAD, S_NEXT_SCAN, S_NEXT_DONE, S_EMIT_READ, S_EMIT_OUT
  } state_t;

  state_t state;

  // Captured transaction
  logic [1:0]          in_op;
  logic [ID_W-1:0]     in_id;
  logic [TIME_W-1:0]   in_deadline;
  logic                in_repeat;
  logic [PERIOD_W-1:0] in_period;
  logic [TIME_W-1:0]   in_now;
  logic [1:0]          cur_status;

  // Slot bookkeeping
  logic [DEPTH-1:0]    valid;
  logic [DEPTH-1:0]    done;
  logic [ORDER_W-1:0]  seq;
  logic [IDX_W:0]      rank;
  logic [IDX_W-1:0]    tgt;
  logic [IDX_W:0]      scan_cnt;
  logic [IDX_W-1:0]    rd_addr_q;
  logic [FIRE_CNT_W-1:0] fire_count;
  logic [FIRE_CNT_W-1:0] k;

  // Re-arm staging
  logic [TIME_W-1:0]   rearm_time;
  logic [ID_W-1:0]     re_id;
  logic [PERIOD_W-1:0] re_period;

  // Memory ports
  logic                slot_we;
  logic [IDX_W-1:0]    slot_waddr;
  logic [IDX_W-1:0]    slot_raddr;
  entry_t              slot_wdata;
  logic [ENTRY_W-1:0]  slot_rdata;
  entry_t              slot_word;
  logic                fire_we;
  logic [FIRE_IDX_W-1:0] fire_waddr;
  logic [FIRE_IDX_W-1:0] fire_raddr;
  fire_t               fire_wdata;
  logic [FIRE_W-1:0]   fire_rdata;
  fire_t               fire_q;

  // Search results
  scan_ctl_t           scan_ctl;
  logic                scan_found;
  logic [IDX_W-1:0]    scan_idx;
  entry_t              scan_best;

  logic                in_scan;
  logic                has_free;
  logic [IDX_W-1:0]    free_idx;
  entry_t              place_word;
  logic [TIME_W:0]     rearm_sum;
  logic [TIME_W-1:0]   rearm_sat;

  assign busy      = (state != S_IDLE);
  assign slot_word = entry_t'(slot_rdata);
  assign fire_q    = fire_t'(fire_rdata);

  // Slot memory and fired-timer buffer
  dtq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  dtq_ram #(
    .WIDTH (FIRE_W),
    .DEPTH (MAX_FIRE)
  ) u_fire_ram (
    .clk   (clk),
    .we    (fire_we),
    .waddr (fire_waddr),
    .wdata (fire_wdata),
    .raddr (fire_raddr),
    .rdata (fire_rdata)
  );

  dtq_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk      (clk),
    .ctl      (scan_ctl),
    .idx      (rd_addr_q),
    .word     (slot_word),
    .found    (scan_found),
    .best_idx (scan_idx),
    .best     (scan_best)
  );

  // Find the lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    has_free = ~&valid;
  end

  // Saturating re-arm time from the buffered period
  always_comb begin
    rearm_sum = {1'b0, in_now} + (TIME_W+1)'(fire_q.period);
    rearm_sat = rearm_sum[TIME_W] ? TIME_MAX : rearm_sum[TIME_W-1:0];
  end

  // Steer the walk over the slot memory
  always_comb begin
    in_scan = (state == S_RENUM_SCAN) || (state == S_DEL_SCAN) ||
              (state == S_DUE_SCAN) || (state == S_NEXT_SCAN);
    slot_raddr          = scan_cnt[IDX_W-1:0];
    scan_ctl.clear      = in_scan && (scan_cnt == '0);
    scan_ctl.feed       = in_scan && (scan_cnt != '0);
    scan_ctl.order_only = (state == S_RENUM_SCAN);
    unique case (state)
      S_DEL_SCAN:   scan_ctl.cand = valid[rd_addr_q] && (slot_word.id == in_id);
      S_DUE_SCAN:   scan_ctl.cand = valid[rd_addr_q] && (slot_word.deadline <= in_now);
      S_RENUM_SCAN: scan_ctl.cand = valid[rd_addr_q] && !done[rd_addr_q];
      default:      scan_ctl.cand = valid[rd_addr_q];
    endcase
  end

  // Drive memory writes
  always_comb begin
    if (in_op == OP_ADD) begin
      place_word.deadline = in_deadline;
      place_word.id       = in_id;
      place_word.rearm    = in_repeat;
      place_word.period   = in_period;
    end else begin
      place_word.deadline = rearm_time;
      place_word.id       = re_id;
      place_word.rearm    = 1'b1;
      place_word.period   = re_period;
    end
    place_word.order = seq;

    slot_we    = 1'b0;
    slot_waddr = tgt;
    slot_wdata = place_word;
    unique case (state)
      S_RENUM_WRITE: begin
        slot_we          = scan_found;
        slot_waddr       = scan_idx;
        slot_wdata       = scan_best;
        slot_wdata.order = ORDER_W'(rank);
      end
      S_PLACE: begin
        slot_we = 1'b1;
      end
      default: begin
        slot_we = 1'b0;
      end
    endcase

    fire_we             = (state == S_DUE_TAKE) && scan_found;
    fire_waddr          = fire_count[FIRE_IDX_W-1:0];
    fire_wdata.slot     = scan_idx;
    fire_wdata.id       = scan_best.id;
    fire_wdata.deadline = scan_best.deadline;
    fire_wdata.rearm    = scan_best.rearm;
    fire_wdata.period   = scan_best.period;
    fire_raddr          = k[FIRE_IDX_W-1:0];
  end

  // Sequencer, slot bookkeeping and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      seq    <= '0;
      strobe <= 1'b0;
    end else begin
      // Flag a result after the summary of a quiet transaction or for each fired timer
      strobe    <= (state == S_EMIT_OUT) ||
                   ((state == S_NEXT_DONE) && !((in_op == OP_TICK) && (fire_count != '0)));
      rd_addr_q <= slot_raddr;
      if (in_scan) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            in_op       <= op;
            in_id       <= timer_id;
            in_deadline <= deadline;
            in_repeat   <= repeat_req;
            in_period   <= period;
            in_now      <= now;
            cur_status  <= STATUS_OK;
            fire_count  <= '0;
            scan_cnt    <= '0;
            unique case (op)
              OP_ADD:  state <= S_ADD;
              OP_DEL:  state <= S_DEL_SCAN;
              OP_TICK: state <= S_DUE_SCAN;
              default: state <= S_IDLE;
            endcase
          end
        end

        // Claim a free slot or report a full table
        S_ADD: begin
          if (has_free) begin
            tgt   <= free_idx;
            state <= S_ORDER;
          end else begin
            cur_status <= STATUS_FULL;
            scan_cnt   <= '0;
            state      <= S_NEXT_SCAN;
          end
        end

        // Renumber live slots when the sequence runs out
        S_ORDER: begin
          if (seq == SEQ_TOP) begin
            done     <= '0;
            rank     <= '0;
            scan_cnt <= '0;
            state    <= S_RENUM_SCAN;
          end else begin
            state <= S_PLACE;
          end
        end

        S_RENUM_SCAN: begin
          if (scan_cnt == SCAN_END) begin
            state <= S_RENUM_WRITE;
          end
        end

        S_RENUM_WRITE: begin
          if (scan_found) begin
            done[scan_idx] <= 1'b1;
            rank           <= rank + 1'b1;
            scan_cnt       <= '0;
            state          <= S_RENUM_SCAN;
          end else begin
            seq   <= ORDER_W'(rank);
            state <= S_PLACE;
          end
        end

        // Write the slot and take the next sequence number
        S_PLACE: begin
          valid[tgt] <= 1'b1;
          seq        <= seq + 1'b1;
          if (in_op == OP_ADD) begin
            scan_cnt <= '0;
            state    <= S_NEXT_SCAN;
          end else begin
            k     <= k + 1'b1;
            state <= S_REARM_READ;
          end
        end

        S_DEL_SCAN: begin
          if (scan_cnt == SCAN_END) begin
            state <= S_DEL_DONE;
          end
        end

        // Drop the first-to-fire match, or report a miss
        S_DEL_DONE: begin
          if (scan_found) begin
            valid[scan_idx] <= 1'b0;
          end else begin
            cur_status <= STATUS_MISS;
          end
          scan_cnt <= '0;
          state    <= S_NEXT_SCAN;
        end

        S_DUE_SCAN: begin
          if (scan_cnt == SCAN_END) begin
            state <= S_DUE_TAKE;
          end
        end

        // Retire the earliest due timer into the fired buffer
        S_DUE_TAKE: begin
          if (scan_found) begin
            valid[scan_idx] <= 1'b0;
            fire_count      <= fire_count + 1'b1;
          end
          if (scan_found && (fire_count + 1'b1 != FIRE_CNT_W'(MAX_FIRE))) begin
            scan_cnt <= '0;
            state    <= S_DUE_SCAN;
          end else begin
            k     <= '0;
            state <= S_REARM_READ;
          end
        end

        S_REARM_READ: begin
          if (k == fire_count) begin
            scan_cnt <= '0;
            state    <= S_NEXT_SCAN;
          end else begin
            state <= S_REARM_LOAD;
          end
        end

        // Stage a repeating timer for re-insertion, skip the others
        S_REARM_LOAD: begin
          if (fire_q.rearm) begin
            tgt        <= fire_q.slot;
            rearm_time <= rearm_sat;
            re_id      <= fire_q.id;
            re_period  <= fire_q.period;
            state      <= S_ORDER;
          end else begin
            k     <= k + 1'b1;
            state <= S_REARM_READ;
          end
        end

        S_NEXT_SCAN: begin
          if (scan_cnt == SCAN_END) begin
            state <= S_NEXT_DONE;
          end
        end

        // Latch the summary; answer at once unless timers fired
        S_NEXT_DONE: begin
          next_valid    <= scan_found;
          next_deadline <= scan_found ? scan_best.deadline : '0;
          if ((in_op == OP_TICK) && (fire_count != '0)) begin
            k     <= '0;
            state <= S_EMIT_READ;
          end else begin
            kind       <= (in_op == OP_TICK) ? KIND_NONE : KIND_ACK;
            fired_id   <= in_id;
            fired_time <= '0;
            status     <= cur_status;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end

        S_EMIT_READ: begin
          state <= S_EMIT_OUT;
        end

        // Present one fired timer
        S_EMIT_OUT: begin
          kind       <= KIND_FIRED;
          fired_id   <= fire_q.id;
          fired_time <= fire_q.deadline;
          status     <= STATUS_OK;
          last       <= (k + 1'b1 == fire_count);
          k          <= k + 1'b1;
          if (k + 1'b1 == fire_count) begin
            state <= S_IDLE;
          end else begin
            state <= S_EMIT_READ;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result that is not the last leaves the block busy
  a_more_results: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> busy)
    else $error("block went idle before the last result");

  // Insertion only lands on a free slot
  a_place_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLACE) |-> !valid[tgt])
    else $error("insertion overwrote a live slot");

  // The fired buffer never overflows
  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUE_TAKE) |-> (fire_count < FIRE_CNT_W'(MAX_FIRE)))
    else $error("fired buffer overflow");

  // An empty queue reports a zero deadline
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !next_valid |-> (next_deadline == '0))
    else $error("nonzero deadline with empty queue");

endmodule
